[rtl/core/blpe_pkg.sv]
// ----------------------------------------------------------------------------
// blpe_pkg
// Shared types and constants for the Bresenham line pixel engine.
// ----------------------------------------------------------------------------
package blpe_pkg;

    localparam int CFG_BITS     = 13;
    localparam int CFG_IDX_BITS = 2;
    localparam int ADDR_BITS    = 24;
    localparam int COLOR_BITS   = 32;

    // request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RESET  = 13'd800;
    localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RESET = 13'd600;

    typedef struct packed {
        logic [CFG_BITS-1:0] width;
        logic [CFG_BITS-1:0] height;
    } frame_cfg_t;

endpackage

[rtl/core/blpe_ifs.sv]
// ----------------------------------------------------------------------------
// blpe_ifs
// Valid/ready channel interfaces: line requests, pixel results, config writes.
// ----------------------------------------------------------------------------
interface blpe_req_if
    import blpe_pkg::*;
#(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0]        pixel_color;

    modport source (
        output valid, req_type, start_x, start_y, end_x, end_y, pixel_color,
        input  ready
    );
    modport sink (
        input  valid, req_type, start_x, start_y, end_x, end_y, pixel_color,
        output ready
    );
endinterface

interface blpe_pix_if
    import blpe_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [ADDR_BITS-1:0]  pixel_address;
    logic [COLOR_BITS-1:0] color_out;
    logic                  inside_frame;
    logic                  last_pixel;

    modport source (
        output valid, pixel_address, color_out, inside_frame, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_address, color_out, inside_frame, last_pixel,
        output ready
    );
endinterface

interface blpe_cfg_if
    import blpe_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [CFG_BITS-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input  valid, index, data, output ready);
endinterface

[rtl/core/bresenham_line_pixel_engine_unit.sv]
// ----------------------------------------------------------------------------
// bresenham_line_pixel_engine_unit
// Bresenham line rasterizer emitting clipped framebuffer pixel writes.
// ----------------------------------------------------------------------------
// Usage:
//   req : request items. A start item loads endpoints and color and emits
//         nothing; a start during a line replaces it. Each step item emits
//         the current pixel and advances it; a step while idle emits nothing.
//   pix : one pixel item per step of an active line: address y*width+x
//         (zero when clipped), color, inside flag, last flag on the endpoint.
//   cfg : register writes (0 frame width, 1 frame height), always ready,
//         values saturate to MAX_WIDTH / MAX_HEIGHT. Write only while idle.
// Timing: one item per cycle sustained while the receiver is ready. A pixel item
//   is valid once its step item has passed the stepper register (line state and
//   error update) and the clip/address stage register (the y*width multiply).
// Reset: line idle, frame 800 x 600, both pipeline stages empty.
// Stall: each stage holds its item while the receiver is not ready and the
//   request side keeps taking items until both stages are full.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_engine_unit
    import blpe_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int COORD_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    blpe_req_if.sink    req,
    blpe_pix_if.source  pix,
    blpe_cfg_if.sink    cfg
);

    frame_cfg_t                   frame;
    logic                         st_valid;
    logic                         st_ready;
    logic signed [COORD_BITS-1:0] st_x;
    logic signed [COORD_BITS-1:0] st_y;
    logic [COLOR_BITS-1:0]        st_color;
    logic                         st_last;

    blpe_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .frame (frame)
    );

    blpe_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .pix_valid (st_valid),
        .pix_ready (st_ready),
        .pix_x     (st_x),
        .pix_y     (st_y),
        .pix_color (st_color),
        .pix_last  (st_last)
    );

    blpe_clip #(
        .COORD_BITS (COORD_BITS)
    ) u_clip (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame),
        .pix_valid (st_valid),
        .pix_ready (st_ready),
        .pix_x     (st_x),
        .pix_y     (st_y),
        .pix_color (st_color),
        .pix_last  (st_last),
        .pix       (pix)
    );

endmodule

[rtl/core/blpe_cfg.sv]
// ----------------------------------------------------------------------------
// blpe_cfg
// Frame size registers with saturation to the supported maximum.
// ----------------------------------------------------------------------------
module blpe_cfg
    import blpe_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic            clk,
    input  logic            rst_n,
    blpe_cfg_if.sink        cfg,
    output frame_cfg_t      frame
);

    frame_cfg_t frame_reg;
    frame_cfg_t frame_next;

    assign cfg.ready = 1'b1;
    assign frame     = frame_reg;

    always_comb
    begin
        frame_next = frame_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_FRAME_WIDTH:
                begin
                    if (int'(cfg.data) > MAX_WIDTH)
                        frame_next.width = CFG_BITS'(MAX_WIDTH);
                    else
                        frame_next.width = cfg.data;
                end
                CFG_FRAME_HEIGHT:
                begin
                    if (int'(cfg.data) > MAX_HEIGHT)
                        frame_next.height = CFG_BITS'(MAX_HEIGHT);
                    else
                        frame_next.height = cfg.data;
                end
                default:
                begin
                    frame_next = frame_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg.width  <= FRAME_WIDTH_RESET;
            frame_reg.height <= FRAME_HEIGHT_RESET;
        end
        else
        begin
            frame_reg <= frame_next;
        end
    end

endmodule

[rtl/core/blpe_step.sv]
// ----------------------------------------------------------------------------
// blpe_step
// Line state and Bresenham stepper; registers the current pixel per step item.
// ----------------------------------------------------------------------------
module blpe_step
    import blpe_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    blpe_req_if.sink                     req,
    output logic                         pix_valid,
    input  logic                         pix_ready,
    output logic signed [COORD_BITS-1:0] pix_x,
    output logic signed [COORD_BITS-1:0] pix_y,
    output logic [COLOR_BITS-1:0]        pix_color,
    output logic                         pix_last
);

    localparam int EW = COORD_BITS + 2;

    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0] target_x_reg, target_x_next;
    logic signed [COORD_BITS-1:0] target_y_reg, target_y_next;
    logic [COORD_BITS-1:0]        delta_x_reg, delta_x_next;
    logic [COORD_BITS-1:0]        delta_y_reg, delta_y_next;
    logic signed [EW-1:0]         err_reg, err_next;
    logic                         neg_x_reg, neg_x_next;
    logic                         neg_y_reg, neg_y_next;
    logic [COLOR_BITS-1:0]        color_reg, color_next;
    logic                         active_reg, active_next;

    logic                         pv_reg, pv_next;
    logic signed [COORD_BITS-1:0] px_reg, px_next;
    logic signed [COORD_BITS-1:0] py_reg, py_next;
    logic [COLOR_BITS-1:0]        pc_reg, pc_next;
    logic                         pl_reg, pl_next;

    logic                         accept;
    logic signed [COORD_BITS:0]   diff_x, diff_y;
    logic [COORD_BITS:0]          ndiff_x, ndiff_y;
    logic [COORD_BITS-1:0]        abs_x, abs_y;
    logic                         at_end;
    logic signed [EW:0]           e2, dx_w, dy_w;
    logic signed [EW-1:0]         dx_e, dy_e;
    logic                         move_x, move_y;

    assign req.ready = !pv_reg || pix_ready;
    assign accept    = req.valid && req.ready;

    assign pix_valid = pv_reg;
    assign pix_x     = px_reg;
    assign pix_y     = py_reg;
    assign pix_color = pc_reg;
    assign pix_last  = pl_reg;

    // endpoint setup
    assign diff_x  = {req.end_x[COORD_BITS-1], req.end_x}
                   - {req.start_x[COORD_BITS-1], req.start_x};
    assign diff_y  = {req.end_y[COORD_BITS-1], req.end_y}
                   - {req.start_y[COORD_BITS-1], req.start_y};
    assign ndiff_x = -diff_x;
    assign ndiff_y = -diff_y;
    assign abs_x   = diff_x[COORD_BITS] ? ndiff_x[COORD_BITS-1:0] : diff_x[COORD_BITS-1:0];
    assign abs_y   = diff_y[COORD_BITS] ? ndiff_y[COORD_BITS-1:0] : diff_y[COORD_BITS-1:0];

    // step decision on 2*err
    assign at_end = (cur_x_reg == target_x_reg) && (cur_y_reg == target_y_reg);
    assign e2     = {err_reg, 1'b0};
    assign dx_w   = $signed((EW+1)'(delta_x_reg));
    assign dy_w   = $signed((EW+1)'(delta_y_reg));
    assign dx_e   = $signed(EW'(delta_x_reg));
    assign dy_e   = $signed(EW'(delta_y_reg));
    assign move_x = e2 > -dy_w;
    assign move_y = e2 < dx_w;

    always_comb
    begin
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        target_x_next = target_x_reg;
        target_y_next = target_y_reg;
        delta_x_next  = delta_x_reg;
        delta_y_next  = delta_y_reg;
        err_next      = err_reg;
        neg_x_next    = neg_x_reg;
        neg_y_next    = neg_y_reg;
        color_next    = color_reg;
        active_next   = active_reg;

        pv_next = pv_reg && !pix_ready;
        px_next = px_reg;
        py_next = py_reg;
        pc_next = pc_reg;
        pl_next = pl_reg;

        if (accept)
        begin
            if (req.req_type == REQ_START)
            begin
                cur_x_next    = req.start_x;
                cur_y_next    = req.start_y;
                target_x_next = req.end_x;
                target_y_next = req.end_y;
                delta_x_next  = abs_x;
                delta_y_next  = abs_y;
                neg_x_next    = !(req.start_x < req.end_x);
                neg_y_next    = !(req.start_y < req.end_y);
                err_next      = $signed(EW'(abs_x)) - $signed(EW'(abs_y));
                color_next    = req.pixel_color;
                active_next   = 1'b1;
            end
            else if (active_reg)
            begin
                pv_next = 1'b1;
                px_next = cur_x_reg;
                py_next = cur_y_reg;
                pc_next = color_reg;
                pl_next = at_end;
                if (at_end)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    err_next = err_reg - (move_x ? dy_e : '0) + (move_y ? dx_e : '0);
                    if (move_x)
                        cur_x_next = neg_x_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                    if (move_y)
                        cur_y_next = neg_y_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            target_x_reg <= '0;
            target_y_reg <= '0;
            delta_x_reg  <= '0;
            delta_y_reg  <= '0;
            err_reg      <= '0;
            neg_x_reg    <= 1'b0;
            neg_y_reg    <= 1'b0;
            color_reg    <= '0;
            active_reg   <= 1'b0;
            pv_reg       <= 1'b0;
        end
        else
        begin
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            target_x_reg <= target_x_next;
            target_y_reg <= target_y_next;
            delta_x_reg  <= delta_x_next;
            delta_y_reg  <= delta_y_next;
            err_reg      <= err_next;
            neg_x_reg    <= neg_x_next;
            neg_y_reg    <= neg_y_next;
            color_reg    <= color_next;
            active_reg   <= active_next;
            pv_reg       <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
        py_reg <= py_next;
        pc_reg <= pc_next;
        pl_reg <= pl_next;
    end

endmodule

[rtl/core/blpe_clip.sv]
// ----------------------------------------------------------------------------
// blpe_clip
// Clip test against the frame and framebuffer address y*width+x, registered.
// ----------------------------------------------------------------------------
module blpe_clip
    import blpe_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  frame_cfg_t                   frame,
    input  logic                         pix_valid,
    output logic                         pix_ready,
    input  logic signed [COORD_BITS-1:0] pix_x,
    input  logic signed [COORD_BITS-1:0] pix_y,
    input  logic [COLOR_BITS-1:0]        pix_color,
    input  logic                         pix_last,
    blpe_pix_if.source                   pix
);

    localparam int CW = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;
    localparam int PW = COORD_BITS + CFG_BITS;

    logic                  ov_reg, ov_next;
    logic [ADDR_BITS-1:0]  addr_reg, addr_next;
    logic [COLOR_BITS-1:0] color_reg, color_next;
    logic                  inside_reg, inside_next;
    logic                  last_reg, last_next;

    logic                  in_frame;
    logic [PW-1:0]         lin_addr;

    assign pix_ready = !ov_reg || pix.ready;

    assign in_frame = !pix_x[COORD_BITS-1] && !pix_y[COORD_BITS-1]
                   && (CW'($unsigned(pix_x)) < CW'(frame.width))
                   && (CW'($unsigned(pix_y)) < CW'(frame.height));

    assign lin_addr = PW'($unsigned(pix_y)) * PW'(frame.width) + PW'($unsigned(pix_x));

    always_comb
    begin
        ov_next     = ov_reg && !pix.ready;
        addr_next   = addr_reg;
        color_next  = color_reg;
        inside_next = inside_reg;
        last_next   = last_reg;
        if (pix_valid && pix_ready)
        begin
            ov_next     = 1'b1;
            addr_next   = in_frame ? ADDR_BITS'(lin_addr) : '0;
            color_next  = pix_color;
            inside_next = in_frame;
            last_next   = pix_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else
            ov_reg <= ov_next;
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        color_reg  <= color_next;
        inside_reg <= inside_next;
        last_reg   <= last_next;
    end

    assign pix.valid         = ov_reg;
    assign pix.pixel_address = addr_reg;
    assign pix.color_out     = color_reg;
    assign pix.inside_frame  = inside_reg;
    assign pix.last_pixel    = last_reg;

endmodule

[verif/bresenham_line_pixel_engine_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bresenham_line_pixel_engine_unit_tb
// Self-checking bench for the line engine. A short table of directed line and
// step items runs first, then randomized lines under several frame sizes, most
// with bursty stalls on both channels. Every pixel item is checked against a
// typed value or a behavioral stepper kept in step with each accepted request.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_engine_unit_tb;
    import blpe_pkg::*;

    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_HEIGHT   = 4096;
    localparam int COORD_BITS   = 16;
    localparam int PIPE_LATENCY = 2;
    localparam int CYCLE_LIMIT  = 300000;

    // index with no register behind it; writes must be ignored
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED = 2'd3;

    typedef enum logic [1:0] {
        ROW_NO_PIXEL,
        ROW_TYPED,
        ROW_PREDICTED
    } row_kind_t;

    typedef struct packed {
        logic        op;
        logic [15:0] x0;
        logic [15:0] y0;
        logic [15:0] x1;
        logic [15:0] y1;
        logic [31:0] color;
    } line_req_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  addr;
        logic [COLOR_BITS-1:0] color;
        logic                  in_frame;
        logic                  is_last;
    } pixel_t;

    typedef struct {
        line_req_t req;
        row_kind_t kind;
        pixel_t    want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    blpe_req_if #(.COORD_BITS(COORD_BITS)) req_ch ();
    blpe_pix_if                            pix_ch ();
    blpe_cfg_if                            cfg_ch ();

    bresenham_line_pixel_engine_unit #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .pix   (pix_ch),
        .cfg   (cfg_ch)
    );

    // line stepper state
    int          ln_x, ln_y, ln_tx, ln_ty;
    int          ln_dx, ln_dy, ln_err;
    bit          ln_xneg, ln_yneg, ln_busy;
    logic [31:0] ln_color;
    int          frame_w, frame_h;

    pixel_t      pending_pixels[$];
    stim_row_t   directed_rows[$];
    int          error_count;
    int          cycle_count;
    int          src_stall_pct;
    int          sink_stall_pct;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // apply one accepted request to the line; returns 1 when a pixel results
    function automatic bit rasterize(input line_req_t r, output pixel_t px);
        int e2;
        int lin;
        bit hit;
        bit at_end;
        px = '0;
        if (r.op == REQ_START)
        begin
            ln_x     = int'($signed(r.x0));
            ln_y     = int'($signed(r.y0));
            ln_tx    = int'($signed(r.x1));
            ln_ty    = int'($signed(r.y1));
            ln_dx    = (ln_tx > ln_x) ? ln_tx - ln_x : ln_x - ln_tx;
            ln_dy    = (ln_ty > ln_y) ? ln_ty - ln_y : ln_y - ln_ty;
            ln_xneg  = !(ln_x < ln_tx);
            ln_yneg  = !(ln_y < ln_ty);
            ln_err   = ln_dx - ln_dy;
            ln_color = r.color;
            ln_busy  = 1'b1;
            return 1'b0;
        end
        if (!ln_busy)
            return 1'b0;
        hit    = ln_x >= 0 && ln_x < frame_w && ln_y >= 0 && ln_y < frame_h;
        at_end = ln_x == ln_tx && ln_y == ln_ty;
        lin    = hit ? ln_y * frame_w + ln_x : 0;
        px.addr     = lin[ADDR_BITS-1:0];
        px.color    = ln_color;
        px.in_frame = hit;
        px.is_last  = at_end;
        if (at_end)
            ln_busy = 1'b0;
        else
        begin
            e2 = 2 * ln_err;
            if (e2 > -ln_dy)
            begin
                ln_err -= ln_dy;
                ln_x   += ln_xneg ? -1 : 1;
            end
            if (e2 < ln_dx)
            begin
                ln_err += ln_dx;
                ln_y   += ln_yneg ? -1 : 1;
            end
        end
        return 1'b1;
    endfunction

    function automatic line_req_t start_req(input int x0, input int y0, input int x1,
                                            input int y1, input logic [31:0] color);
        line_req_t r;
        r.op    = REQ_START;
        r.x0    = 16'(x0);
        r.y0    = 16'(y0);
        r.x1    = 16'(x1);
        r.y1    = 16'(y1);
        r.color = color;
        return r;
    endfunction

    // coordinate payload of a step item is don't-care; randomize it anyway
    function automatic line_req_t step_req();
        line_req_t r;
        r.op    = REQ_STEP;
        r.x0    = 16'($urandom);
        r.y0    = 16'($urandom);
        r.x1    = 16'($urandom);
        r.y1    = 16'($urandom);
        r.color = $urandom;
        return r;
    endfunction

    function automatic pixel_t typed_pixel(input int addr, input logic [31:0] color,
                                           input bit hit, input bit at_end);
        pixel_t px;
        px.addr     = addr[ADDR_BITS-1:0];
        px.color    = color;
        px.in_frame = hit;
        px.is_last  = at_end;
        return px;
    endfunction

    // pick a coordinate near the low edge, near the high edge, or anywhere inside
    function automatic int near_edge(input int span);
        case ($urandom_range(0, 2))
            0:       return int'($urandom_range(0, 12)) - 6;
            1:       return span + int'($urandom_range(0, 12)) - 7;
            default: return int'($urandom_range(0, span));
        endcase
    endfunction

    function automatic line_req_t short_line();
        int x0;
        int y0;
        x0 = near_edge(frame_w);
        y0 = near_edge(frame_h);
        return start_req(x0, y0, x0 + int'($urandom_range(0, 40)) - 20,
                         y0 + int'($urandom_range(0, 40)) - 20, $urandom);
    endfunction

    task automatic send_request(input line_req_t r, input row_kind_t kind = ROW_PREDICTED,
                                input pixel_t want = '0);
        pixel_t px;
        bit     got;
        if (src_stall_pct != 0 && $urandom_range(0, 99) < src_stall_pct)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 18)) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= r.op;
        req_ch.start_x     <= r.x0;
        req_ch.start_y     <= r.y0;
        req_ch.end_x       <= r.x1;
        req_ch.end_y       <= r.y1;
        req_ch.pixel_color <= r.color;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        got = rasterize(r, px);
        case (kind)
            ROW_TYPED:     pending_pixels.push_back(want);
            ROW_PREDICTED: if (got) pending_pixels.push_back(px);
            default:       ;
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        if (idx == CFG_FRAME_WIDTH)
            frame_w = (int'(value) > MAX_WIDTH) ? MAX_WIDTH : int'(value);
        else if (idx == CFG_FRAME_HEIGHT)
            frame_h = (int'(value) > MAX_HEIGHT) ? MAX_HEIGHT : int'(value);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // stop requests, wait out every pixel, then let the pipeline empty
    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic set_stall(input int pct);
        src_stall_pct  = pct;
        sink_stall_pct = pct;
    endtask

    task automatic run_random(input int n_items);
        int sent;
        int pick;
        int n;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                // whole line, stepped to its endpoint
                send_request(short_line());
                sent++;
                while (ln_busy)
                begin
                    send_request(step_req());
                    sent++;
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    send_request(step_req());
                    sent++;
                end
            end
            else if (pick < 80)
            begin
                // line cut short by the next start
                send_request(short_line());
                n = $urandom_range(1, 6);
                repeat (n) send_request(step_req());
                sent += n + 1;
            end
            else if (pick < 92)
            begin
                // full-range endpoints, only a few pixels taken
                send_request(start_req($urandom, $urandom, $urandom, $urandom, $urandom));
                n = $urandom_range(0, 4);
                repeat (n) send_request(step_req());
                sent += n + 1;
            end
            else
            begin
                n = $urandom_range(1, 3);
                repeat (n) send_request(step_req());
                sent += n;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        pixel_t exp_px;
        if (rst_n && pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("pixel item with none expected: addr %0h", pix_ch.pixel_address);
                error_count++;
            end
            else
            begin
                exp_px = pending_pixels.pop_front();
                check_field("pixel_address", 32'(exp_px.addr), 32'(pix_ch.pixel_address));
                check_field("color_out", exp_px.color, pix_ch.color_out);
                check_field("inside_frame", 32'(exp_px.in_frame), 32'(pix_ch.inside_frame));
                check_field("last_pixel", 32'(exp_px.is_last), 32'(pix_ch.last_pixel));
            end
        end
    end

    // receiver: ready drops in bursts
    initial
    begin
        pix_ch.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (rst_n && sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct)
            begin
                pix_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 18)) @(negedge clk);
            end
            else
                pix_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        stim_row_t row;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_START;
        req_ch.start_x     = '0;
        req_ch.start_y     = '0;
        req_ch.end_x       = '0;
        req_ch.end_y       = '0;
        req_ch.pixel_color = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_FRAME_WIDTH;
        cfg_ch.data        = '0;
        error_count        = 0;
        cycle_count        = 0;
        frame_w            = int'(FRAME_WIDTH_RESET);
        frame_h            = int'(FRAME_HEIGHT_RESET);
        ln_x = 0; ln_y = 0; ln_tx = 0; ln_ty = 0;
        ln_dx = 0; ln_dy = 0; ln_err = 0;
        ln_xneg = 1'b0; ln_yneg = 1'b0; ln_busy = 1'b0; ln_color = '0;
        set_stall(15);

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed rows, reset frame of 800 x 600
        directed_rows.push_back('{step_req(), ROW_NO_PIXEL, '0});
        directed_rows.push_back('{start_req(0, 0, 0, 0, 32'hFFFF_FFFF), ROW_NO_PIXEL, '0});
        directed_rows.push_back('{step_req(), ROW_TYPED,
                                  typed_pixel(0, 32'hFFFF_FFFF, 1'b1, 1'b1)});
        directed_rows.push_back('{step_req(), ROW_NO_PIXEL, '0});
        directed_rows.push_back('{start_req(799, 599, 799, 599, 32'h0), ROW_NO_PIXEL, '0});
        directed_rows.push_back('{step_req(), ROW_TYPED,
                                  typed_pixel(479999, 32'h0, 1'b1, 1'b1)});
        directed_rows.push_back('{start_req(800, 599, 800, 599, 32'hA5A5_A5A5),
                                  ROW_NO_PIXEL, '0});
        directed_rows.push_back('{step_req(), ROW_TYPED,
                                  typed_pixel(0, 32'hA5A5_A5A5, 1'b0, 1'b1)});
        directed_rows.push_back('{start_req(-1, -1, -1, -1, 32'h5A5A_5A5A), ROW_NO_PIXEL, '0});
        directed_rows.push_back('{step_req(), ROW_TYPED,
                                  typed_pixel(0, 32'h5A5A_5A5A, 1'b0, 1'b1)});
        directed_rows.push_back('{start_req(-32768, 32767, 32767, -32768, 32'h1234_5678),
                                  ROW_NO_PIXEL, '0});
        directed_rows.push_back('{step_req(), ROW_TYPED,
                                  typed_pixel(0, 32'h1234_5678, 1'b0, 1'b0)});
        directed_rows.push_back('{step_req(), ROW_PREDICTED, '0});
        // replaces the full-range line while it is still running
        directed_rows.push_back('{start_req(0, 0, 5, 2, 32'h0F0F_0F0F), ROW_NO_PIXEL, '0});
        repeat (6) directed_rows.push_back('{step_req(), ROW_PREDICTED, '0});
        directed_rows.push_back('{start_req(3, 7, 1, 0, 32'hC3C3_C3C3), ROW_NO_PIXEL, '0});
        repeat (2) directed_rows.push_back('{step_req(), ROW_PREDICTED, '0});
        // crosses the bottom-right corner of the frame
        directed_rows.push_back('{start_req(798, 598, 801, 601, 32'h8000_0001),
                                  ROW_NO_PIXEL, '0});
        repeat (4) directed_rows.push_back('{step_req(), ROW_PREDICTED, '0});

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_request(row.req, row.kind, row.want);
        end
        drain();

        set_stall(25);
        write_reg(CFG_FRAME_WIDTH, 13'd1);
        write_reg(CFG_FRAME_HEIGHT, 13'd1);
        run_random(140);
        drain();

        set_stall(10);
        write_reg(CFG_FRAME_WIDTH, 13'd0);
        write_reg(CFG_FRAME_HEIGHT, 13'd0);
        write_reg(CFG_UNMAPPED, 13'h1FFF);
        run_random(120);
        drain();

        set_stall(0);
        write_reg(CFG_FRAME_WIDTH, 13'h1FFF);
        write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
        run_random(140);
        drain();

        set_stall(20);
        write_reg(CFG_FRAME_WIDTH, 13'd4096);
        write_reg(CFG_FRAME_HEIGHT, 13'd4096);
        run_random(140);
        drain();

        set_stall(15);
        write_reg(CFG_FRAME_WIDTH, 13'($urandom_range(0, 8191)));
        write_reg(CFG_FRAME_HEIGHT, 13'($urandom_range(0, 8191)));
        run_random(140);
        drain();

        // closing stretch runs at full rate
        set_stall(0);
        write_reg(CFG_FRAME_WIDTH, 13'($urandom_range(1, 64)));
        write_reg(CFG_FRAME_HEIGHT, 13'($urandom_range(1, 64)));
        run_random(150);
        drain();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
